// ===== rtl/assert_macros.svh =====
// Assertion macros for the ARX model step block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Concurrent check, disabled while reset is held.
`define ARX_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Concurrent check, live through reset.
`define ARX_ASSERT_NORST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ARX_ASSERT(lbl, clk, rstn, prop, msg)
`define ARX_ASSERT_NORST(lbl, clk, prop, msg)
`endif
`endif

// ===== rtl/arx_pkg.sv =====
// Shared types, constants and helpers for the ARX model step block.
`default_nettype none
package arx_pkg;

    localparam int COEF_W      = 16;
    localparam int COEF_FRAC   = 14;
    localparam int COEF_SLOTS  = 4;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int DELAY_W     = 5;
    localparam int CLAMP_EN_W  = 2;
    localparam int CLAMP_Y_BIT = 0;
    localparam int CLAMP_U_BIT = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_A_COEFFS  = 3'd0,
        REG_B_COEFFS  = 3'd1,
        REG_DELAY     = 3'd2,
        REG_Y_TOP     = 3'd3,
        REG_Y_BOTTOM  = 3'd4,
        REG_U_TOP     = 3'd5,
        REG_U_BOTTOM  = 3'd6,
        REG_CLAMP_EN  = 3'd7
    } cfg_reg_t;

    // Width-independent part of the configuration
    typedef struct packed {
        logic [CFG_DATA_W-1:0] a_coeffs;
        logic [CFG_DATA_W-1:0] b_coeffs;
        logic [DELAY_W-1:0]    delay;
        logic [CLAMP_EN_W-1:0] clamp_enables;
    } cfg_ctrl_t;

    // Tap idx of a packed coefficient word; taps past the fourth read as zero
    function automatic logic signed [COEF_W-1:0] coef_tap(
        input logic [CFG_DATA_W-1:0] pk,
        input int unsigned           idx
    );
        logic signed [COEF_W-1:0] c;
        c = '0;
        if (idx < COEF_SLOTS) begin
            c = signed'(pk[COEF_W*idx +: COEF_W]);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/arx_cfg.sv =====
// Configuration register file for the ARX model step block.
`default_nettype none
module arx_cfg
    import arx_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [CFG_IDX_W-1:0]           cfg_index,
    input  logic [CFG_DATA_W-1:0]          cfg_wdata,
    output cfg_ctrl_t                      ctrl,
    output logic signed [SAMPLE_WIDTH-1:0] y_top,
    output logic signed [SAMPLE_WIDTH-1:0] y_bottom,
    output logic signed [SAMPLE_WIDTH-1:0] u_top,
    output logic signed [SAMPLE_WIDTH-1:0] u_bottom
);

    localparam logic [SAMPLE_WIDTH-1:0] SMAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic [SAMPLE_WIDTH-1:0] SMIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    cfg_ctrl_t                      ctrl_reg;
    logic signed [SAMPLE_WIDTH-1:0] y_top_reg;
    logic signed [SAMPLE_WIDTH-1:0] y_bottom_reg;
    logic signed [SAMPLE_WIDTH-1:0] u_top_reg;
    logic signed [SAMPLE_WIDTH-1:0] u_bottom_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg.a_coeffs      <= '0;
            ctrl_reg.b_coeffs      <= '0;
            ctrl_reg.delay         <= DELAY_W'(1);
            ctrl_reg.clamp_enables <= '0;
            y_top_reg              <= SMAX;
            y_bottom_reg           <= SMIN;
            u_top_reg              <= SMAX;
            u_bottom_reg           <= SMIN;
        end else if (cfg_we) begin
            case (cfg_reg_t'(cfg_index))
                REG_A_COEFFS: ctrl_reg.a_coeffs      <= cfg_wdata;
                REG_B_COEFFS: ctrl_reg.b_coeffs      <= cfg_wdata;
                REG_DELAY:    ctrl_reg.delay         <= cfg_wdata[DELAY_W-1:0];
                REG_Y_TOP:    y_top_reg              <= signed'(cfg_wdata[SAMPLE_WIDTH-1:0]);
                REG_Y_BOTTOM: y_bottom_reg           <= signed'(cfg_wdata[SAMPLE_WIDTH-1:0]);
                REG_U_TOP:    u_top_reg              <= signed'(cfg_wdata[SAMPLE_WIDTH-1:0]);
                REG_U_BOTTOM: u_bottom_reg           <= signed'(cfg_wdata[SAMPLE_WIDTH-1:0]);
                REG_CLAMP_EN: ctrl_reg.clamp_enables <= cfg_wdata[CLAMP_EN_W-1:0];
                default: ;
            endcase
        end
    end

    assign ctrl     = ctrl_reg;
    assign y_top    = y_top_reg;
    assign y_bottom = y_bottom_reg;
    assign u_top    = u_top_reg;
    assign u_bottom = u_bottom_reg;

endmodule
`default_nettype wire

// ===== rtl/arx_datapath.sv =====
// Tap products, sum, scaling, saturation and clamps for one ARX sample.
`default_nettype none
module arx_datapath
    import arx_pkg::*;
#(
    parameter int NTAPS        = 4,
    parameter int SAMPLE_WIDTH = 16
) (
    input  cfg_ctrl_t                      ctrl,
    input  logic signed [SAMPLE_WIDTH-1:0] y_top,
    input  logic signed [SAMPLE_WIDTH-1:0] y_bottom,
    input  logic signed [SAMPLE_WIDTH-1:0] u_top,
    input  logic signed [SAMPLE_WIDTH-1:0] u_bottom,
    input  logic signed [SAMPLE_WIDTH-1:0] u_win [NTAPS],
    input  logic signed [SAMPLE_WIDTH-1:0] y_hist [NTAPS],
    input  logic signed [SAMPLE_WIDTH-1:0] u_new,
    output logic signed [SAMPLE_WIDTH-1:0] y_res,
    output logic signed [SAMPLE_WIDTH-1:0] u_store
);

    localparam int PW    = COEF_W + SAMPLE_WIDTH;
    localparam int ACC_W = PW + $clog2(2 * NTAPS) + 1;

    function automatic logic signed [SAMPLE_WIDTH-1:0] clamp_to(
        input logic signed [SAMPLE_WIDTH-1:0] v,
        input logic signed [SAMPLE_WIDTH-1:0] top,
        input logic signed [SAMPLE_WIDTH-1:0] bottom
    );
        logic signed [SAMPLE_WIDTH-1:0] r;
        r = v;
        // the top test is checked first, so it wins when the bounds are crossed
        if (v > top) begin
            r = top;
        end else if (v < bottom) begin
            r = bottom;
        end
        return r;
    endfunction

    logic signed [PW-1:0]           b_prod [NTAPS];
    logic signed [PW-1:0]           a_prod [NTAPS];
    logic signed [ACC_W-1:0]        acc;
    logic signed [ACC_W-1:0]        scaled;
    logic                           in_range;
    logic signed [SAMPLE_WIDTH-1:0] y_sat;

    for (genvar i = 0; i < NTAPS; i++) begin : g_tap
        assign b_prod[i] = coef_tap(ctrl.b_coeffs, i) * u_win[i];
        assign a_prod[i] = coef_tap(ctrl.a_coeffs, i) * y_hist[i];
    end

    always_comb begin
        acc = '0;
        for (int i = 0; i < NTAPS; i++) begin
            acc = acc + ACC_W'(b_prod[i]) - ACC_W'(a_prod[i]);
        end
    end

    // floor division by 2^14
    assign scaled   = acc >>> COEF_FRAC;
    assign in_range = (&scaled[ACC_W-1:SAMPLE_WIDTH-1]) | ~(|scaled[ACC_W-1:SAMPLE_WIDTH-1]);

    always_comb begin
        if (in_range) begin
            y_sat = scaled[SAMPLE_WIDTH-1:0];
        end else if (scaled[ACC_W-1]) begin
            y_sat = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
        end else begin
            y_sat = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
        end
    end

    assign y_res   = ctrl.clamp_enables[CLAMP_Y_BIT] ? clamp_to(y_sat, y_top, y_bottom) : y_sat;
    assign u_store = ctrl.clamp_enables[CLAMP_U_BIT] ? clamp_to(u_new, u_top, u_bottom) : u_new;

endmodule
`default_nettype wire

// ===== rtl/arx_model_step.sv =====
// Top level of the ARX model step block: handshake, sample histories, result register.
//
//  channel  | ports                          | carries
//  ---------+--------------------------------+---------------------------------------
//  input    | s_valid, s_ready, s_u_in       | one input sample per word, Q8.8
//  result   | m_valid, m_ready, m_y_out      | one model output per word, Q8.8
//  config   | cfg_we, cfg_index, cfg_wdata   | register writes, no read-back
//
// A word is taken into the input register, then computed and written into the result
// register; one word per cycle sustained while m_ready stays high.
// That rate is set by the output feedback loop: eight multipliers, the sum and the
// saturate/clamp chain run combinationally from the histories back into them.
// The result register stalls under m_ready low; the input register then holds its word
// and s_ready drops only when both are full.
// Synchronous active-low reset zeroes both histories and empties both registers.
`default_nettype none
`include "assert_macros.svh"
module arx_model_step
    import arx_pkg::*;
#(
    parameter int NTAPS        = 4,
    parameter int MAX_DELAY    = 16,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input words
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] s_u_in,
    // result words
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [SAMPLE_WIDTH-1:0] m_y_out,
    // configuration writes
    input  logic                           cfg_we,
    input  logic [CFG_IDX_W-1:0]           cfg_index,
    input  logic [CFG_DATA_W-1:0]          cfg_wdata
);

    localparam int U_DEPTH = MAX_DELAY + NTAPS - 1;
    localparam int UW      = (U_DEPTH > 1) ? $clog2(U_DEPTH) : 1;
    localparam int KW      = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
    // wide enough for any 5-bit delay and for MAX_DELAY up to 64
    localparam int DX_W    = 7;

    cfg_ctrl_t                      ctrl;
    logic signed [SAMPLE_WIDTH-1:0] y_top;
    logic signed [SAMPLE_WIDTH-1:0] y_bottom;
    logic signed [SAMPLE_WIDTH-1:0] u_top;
    logic signed [SAMPLE_WIDTH-1:0] u_bottom;

    // Input register
    logic                           stg_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] stg_u_reg;
    // Result register
    logic                           m_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] m_y_out_reg;
    // Histories, newest first
    logic signed [SAMPLE_WIDTH-1:0] u_hist_reg [U_DEPTH];
    logic signed [SAMPLE_WIDTH-1:0] y_hist_reg [NTAPS];

    logic                           adv;
    logic [DX_W-1:0]                dly_ext;
    logic [DX_W-1:0]                k_m1;
    logic [KW-1:0]                  kidx;
    logic signed [SAMPLE_WIDTH-1:0] u_win [NTAPS];
    logic signed [SAMPLE_WIDTH-1:0] y_res;
    logic signed [SAMPLE_WIDTH-1:0] u_store;

    arx_cfg #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .ctrl      (ctrl),
        .y_top     (y_top),
        .y_bottom  (y_bottom),
        .u_top     (u_top),
        .u_bottom  (u_bottom)
    );

    // The stored word moves on when the result register is free or being emptied
    assign adv     = stg_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !stg_valid_reg || adv;

    // Delay k: zero acts as one, anything past MAX_DELAY sticks at MAX_DELAY
    assign dly_ext = DX_W'(ctrl.delay);
    always_comb begin
        if (dly_ext == '0) begin
            k_m1 = '0;
        end else if (dly_ext > DX_W'(MAX_DELAY)) begin
            k_m1 = DX_W'(MAX_DELAY - 1);
        end else begin
            k_m1 = dly_ext - DX_W'(1);
        end
    end
    assign kidx = k_m1[KW-1:0];

    // Window of NTAPS consecutive past inputs starting k-1 back
    for (genvar i = 0; i < NTAPS; i++) begin : g_win
        assign u_win[i] = u_hist_reg[UW'(kidx) + UW'(i)];
    end

    arx_datapath #(
        .NTAPS        (NTAPS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_dp (
        .ctrl     (ctrl),
        .y_top    (y_top),
        .y_bottom (y_bottom),
        .u_top    (u_top),
        .u_bottom (u_bottom),
        .u_win    (u_win),
        .y_hist   (y_hist_reg),
        .u_new    (stg_u_reg),
        .y_res    (y_res),
        .u_store  (u_store)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            stg_valid_reg <= 1'b1;
        end else if (adv) begin
            stg_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            stg_u_reg <= s_u_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_y_out_reg <= y_res;
        end
    end

    // Histories shift only as a word is computed, so order follows the input order
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < U_DEPTH; j++) begin
                u_hist_reg[j] <= '0;
            end
            for (int j = 0; j < NTAPS; j++) begin
                y_hist_reg[j] <= '0;
            end
        end else if (adv) begin
            u_hist_reg[0] <= u_store;
            for (int j = 1; j < U_DEPTH; j++) begin
                u_hist_reg[j] <= u_hist_reg[j-1];
            end
            y_hist_reg[0] <= y_res;
            for (int j = 1; j < NTAPS; j++) begin
                y_hist_reg[j] <= y_hist_reg[j-1];
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_y_out = m_y_out_reg;

    // Checks
    `ARX_ASSERT_NORST(a_rst_empties, aclk, !aresetn |=> !m_valid_reg && !stg_valid_reg, "reset left a word in flight")
    `ARX_ASSERT(a_hold_stage, aclk, aresetn, (stg_valid_reg && !adv) |=> stg_valid_reg && $stable(stg_u_reg), "stored input word lost or changed while stalled")
    `ARX_ASSERT(a_ready_full, aclk, aresetn, !s_ready |-> (stg_valid_reg && m_valid_reg && !m_ready), "input refused with room to spare")
    `ARX_ASSERT(a_feedback, aclk, aresetn, adv |=> (m_valid_reg && (y_hist_reg[0] == m_y_out_reg)), "delivered word differs from fed-back output")
    `ARX_ASSERT(a_y_clamp, aclk, aresetn, (adv && ctrl.clamp_enables[CLAMP_Y_BIT] && (y_bottom <= y_top)) |=> ((m_y_out_reg <= $past(y_top)) && (m_y_out_reg >= $past(y_bottom))), "output outside clamp bounds")

endmodule
`default_nettype wire

// ===== tb/arx_model_step_tb.sv =====
// Self-checking testbench for arx_model_step: random and corner samples against a predictor.
module arx_model_step_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import arx_pkg::*;

    localparam int SW      = 16;
    localparam int NT      = 4;
    localparam int MAXD    = 16;
    localparam int U_DEPTH = MAXD + NT - 1;

    // ---------------------------------------------------------------- DUT ports
    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    logic signed [SW-1:0]   s_u_in    = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    logic signed [SW-1:0]   m_y_out;
    logic                   cfg_we    = 1'b0;
    cfg_reg_t               cfg_index = REG_A_COEFFS;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    arx_model_step #(
        .NTAPS        (NT),
        .MAX_DELAY    (MAXD),
        .SAMPLE_WIDTH (SW)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_u_in    (s_u_in),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_y_out   (m_y_out),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // ---------------------------------------------------------------- predictor state
    // Local copy of the register file, as the block should hold it.
    logic [CFG_DATA_W-1:0]  a_cw     = '0;
    logic [CFG_DATA_W-1:0]  b_cw     = '0;
    logic [DELAY_W-1:0]     k_cfg    = DELAY_W'(1);
    logic signed [SW-1:0]   yt       = 16'sh7FFF;
    logic signed [SW-1:0]   yb       = 16'sh8000;
    logic signed [SW-1:0]   ut       = 16'sh7FFF;
    logic signed [SW-1:0]   ub       = 16'sh8000;
    logic [CLAMP_EN_W-1:0]  clamp_en = '0;

    // Sample histories, newest first; both start at zero, matching the block after reset.
    logic signed [SW-1:0]   u_hist [U_DEPTH] = '{default: '0};
    logic signed [SW-1:0]   y_hist [NT]      = '{default: '0};

    // ---------------------------------------------------------------- bookkeeping
    logic [SW-1:0]          u_backlog [$];   // samples waiting for the driver
    logic signed [SW-1:0]   y_due     [$];   // predicted outputs, oldest first

    int          src_idle_pct = 0;
    int          snk_stall_pct = 0;
    int          src_gap = 0;
    int          snk_gap = 0;
    int unsigned words_queued = 0;
    int unsigned words_in = 0;
    int unsigned words_out = 0;
    int unsigned faults = 0;
    int unsigned reg_writes = 0;
    int unsigned settings = 0;
    int unsigned n_sat = 0;
    int unsigned n_yclamp = 0;
    int unsigned n_uclamp = 0;

    logic [SW-1:0] corner_vals [5] = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001};
    logic [SW-1:0] coef_corners [6] = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF,
                                        16'h0001, 16'h4000};
    logic [DELAY_W-1:0] dly_corners [6] = '{5'd0, 5'd1, 5'd2, 5'd16, 5'd17, 5'd31};

    // One model step: returns the output for this sample and advances the histories.
    function automatic logic signed [SW-1:0] arx_next_y(input logic signed [SW-1:0] u_raw);
        longint               acc;
        longint               ys;
        longint               uv;
        int                   k;
        int                   ui;
        logic signed [SW-1:0] uc;
        acc = 0;
        k = int'(k_cfg);
        if (k < 1) begin
            k = 1;
        end
        if (k > MAXD) begin
            k = MAXD;
        end
        for (int i = 0; i < NT; i++) begin
            ui = k - 1 + i;
            uv = (ui < U_DEPTH) ? longint'(u_hist[ui]) : 0;
            acc += longint'($signed(b_cw[16*i +: 16])) * uv;
            acc -= longint'($signed(a_cw[16*i +: 16])) * longint'(y_hist[i]);
        end
        // arithmetic shift floors, matching the block's truncation
        ys = acc >>> COEF_FRAC;
        if (ys > 32767 || ys < -32768) begin
            n_sat++;
        end
        if (ys > 32767) begin
            ys = 32767;
        end
        if (ys < -32768) begin
            ys = -32768;
        end
        // top test wins when the bounds are crossed
        if (clamp_en[CLAMP_Y_BIT]) begin
            if (ys > yt) begin
                ys = yt;
                n_yclamp++;
            end else if (ys < yb) begin
                ys = yb;
                n_yclamp++;
            end
        end
        for (int i = NT - 1; i > 0; i--) begin
            y_hist[i] = y_hist[i-1];
        end
        y_hist[0] = ys[SW-1:0];

        uc = u_raw;
        if (clamp_en[CLAMP_U_BIT]) begin
            if (u_raw > ut) begin
                uc = ut;
                n_uclamp++;
            end else if (u_raw < ub) begin
                uc = ub;
                n_uclamp++;
            end
        end
        for (int i = U_DEPTH - 1; i > 0; i--) begin
            u_hist[i] = u_hist[i-1];
        end
        u_hist[0] = uc;
        return ys[SW-1:0];
    endfunction

    // ---------------------------------------------------------------- input driver
    // Presents samples from the backlog; idles in random bursts.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_u_in  <= '0;
            src_gap = 0;
        end else begin
            if (s_valid && s_ready) begin
                y_due = {y_due, arx_next_y(s_u_in)};
                words_in++;
            end
            if (!s_valid || s_ready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_valid <= 1'b0;
                end else if (u_backlog.size() != 0) begin
                    if ($urandom_range(0, 99) < src_idle_pct) begin
                        src_gap = $urandom_range(1, 11) - 1;
                        s_valid <= 1'b0;
                    end else begin
                        s_valid <= 1'b1;
                        s_u_in  <= u_backlog[0];
                        u_backlog.delete(0);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------- result monitor
    // Checks each accepted word against the oldest prediction; stalls in bursts too.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            snk_gap = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (y_due.size() == 0) begin
                    if (faults < 10) begin
                        $display("[%0t] unexpected result word y_out=%0d", $realtime, m_y_out);
                    end
                    faults++;
                end else begin
                    if (m_y_out !== y_due[0]) begin
                        if (faults < 10) begin
                            $display("[%0t] mismatch on result %0d: y_out expected %0d, got %0d",
                                     $realtime, words_out, y_due[0], m_y_out);
                        end
                        faults++;
                    end
                    y_due.delete(0);
                end
                words_out++;
            end
            if (snk_gap > 0) begin
                snk_gap--;
                m_ready <= 1'b0;
            end else if ($urandom_range(0, 99) < snk_stall_pct) begin
                snk_gap = $urandom_range(1, 11) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------- helpers
    // Register write: one cycle of enable, with the predictor's copy updated as the enable is raised.
    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_A_COEFFS: a_cw     = val;
            REG_B_COEFFS: b_cw     = val;
            REG_DELAY:    k_cfg    = val[DELAY_W-1:0];
            REG_Y_TOP:    yt       = val[SW-1:0];
            REG_Y_BOTTOM: yb       = val[SW-1:0];
            REG_U_TOP:    ut       = val[SW-1:0];
            REG_U_BOTTOM: ub       = val[SW-1:0];
            REG_CLAMP_EN: clamp_en = val[CLAMP_EN_W-1:0];
            default: ;
        endcase
        reg_writes++;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Append one sample to the driver's backlog.
    task automatic queue_word(input logic [SW-1:0] w);
        u_backlog = {u_backlog, w};
        words_queued++;
    endtask

    // Hold off until every queued sample has come back as a result, then let the
    // two-stage pipe settle.
    task automatic drain();
        while (words_out < words_queued) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    // ---------------------------------------------------------------- stimulus
    initial begin
        logic [127:0]       coefs;   // B taps in the upper half, A taps in the lower
        logic [SW-1:0]      tap;
        logic [SW-1:0]      hi;
        logic [SW-1:0]      lo;
        logic [SW-1:0]      v;
        logic [SW-1:0]      last_v;
        logic [DELAY_W-1:0] dly;
        int                 cstyle;
        int                 n_items;
        int                 usel;
        int                 n_phases;

        last_v   = '0;
        n_phases = 14;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: full-scale coefficients and samples, so the sum saturates both ways.
        write_reg(REG_A_COEFFS, {16'h0001, 16'hFFFF, 16'h8000, 16'h7FFF});
        write_reg(REG_B_COEFFS, {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF});
        write_reg(REG_DELAY, 64'd1);
        write_reg(REG_Y_TOP, 64'h7FFF);
        write_reg(REG_Y_BOTTOM, 64'h8000);
        write_reg(REG_U_TOP, 64'h7FFF);
        write_reg(REG_U_BOTTOM, 64'h8000);
        write_reg(REG_CLAMP_EN, 64'd0);
        settings++;
        foreach (corner_vals[j]) queue_word(corner_vals[j]);
        foreach (corner_vals[j]) queue_word(corner_vals[4-j]);
        drain();

        // Directed: zero delay acts as one; pass-through gain of one, output clamped
        // to +-1.0 and the input clamp with crossed bounds.
        write_reg(REG_A_COEFFS, 64'd0);
        write_reg(REG_B_COEFFS, 64'h0000_0000_0000_4000);
        write_reg(REG_DELAY, 64'd0);
        write_reg(REG_Y_TOP, 64'h0100);
        write_reg(REG_Y_BOTTOM, 64'hFF00);
        write_reg(REG_U_TOP, 64'h8000);
        write_reg(REG_U_BOTTOM, 64'h7FFF);
        write_reg(REG_CLAMP_EN, 64'd3);
        settings++;
        queue_word(16'h7FFF);
        queue_word(16'h8000);
        queue_word(16'h0200);
        queue_word(16'hFE00);
        queue_word(16'h0050);
        drain();

        // Directed: delay beyond the maximum saturates; output clamp with crossed bounds.
        write_reg(REG_DELAY, 64'd31);
        write_reg(REG_Y_TOP, 64'hFF9C);
        write_reg(REG_Y_BOTTOM, 64'h0064);
        write_reg(REG_CLAMP_EN, 64'd1);
        settings++;
        foreach (corner_vals[j]) queue_word(corner_vals[j]);
        foreach (corner_vals[j]) queue_word(corner_vals[j] ^ 16'h00FF);
        drain();

        // Random phases: a fresh setting each time, histories carried across.
        for (int ph = 0; ph < n_phases; ph++) begin
            if (ph == n_phases - 1) begin
                // closing stretch runs flat out on both sides
                src_idle_pct  = 0;
                snk_stall_pct = 0;
                n_items       = 150;
            end else begin
                src_idle_pct  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
                snk_stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
                n_items       = $urandom_range(80, 160);
            end

            // 0: anything goes, 1: small stable feedback, 2: corner taps, 3: pure FIR
            cstyle = $urandom_range(0, 3);
            for (int t = 0; t < 2 * NT; t++) begin
                case (cstyle)
                    0: tap = 16'($urandom);
                    1: tap = (t < NT) ? 16'($urandom_range(0, 4095) - 2048)
                                      : 16'($urandom_range(0, 16383) - 8192);
                    2: tap = coef_corners[$urandom_range(0, 5)];
                    default: tap = (t < NT) ? 16'h0000 : 16'($urandom);
                endcase
                coefs[16*t +: 16] = tap;
            end
            write_reg(REG_A_COEFFS, coefs[63:0]);
            write_reg(REG_B_COEFFS, coefs[127:64]);

            dly = ($urandom_range(0, 1) == 0) ? dly_corners[$urandom_range(0, 5)]
                                              : 5'($urandom_range(0, 31));
            write_reg(REG_DELAY, {32'($urandom), 27'($urandom), dly});

            // bounds: mostly ordered, sometimes crossed, now and then the full range;
            // upper data bits carry junk that the block must ignore
            for (int b = 0; b < 2; b++) begin
                hi = 16'($urandom);
                lo = 16'($urandom);
                if ($urandom_range(0, 3) != 0 && $signed(hi) < $signed(lo)) begin
                    {hi, lo} = {lo, hi};
                end
                if ($urandom_range(0, 7) == 0) begin
                    hi = 16'h7FFF;
                    lo = 16'h8000;
                end
                write_reg((b == 0) ? REG_Y_TOP : REG_U_TOP,
                          {32'($urandom), 16'($urandom), hi});
                write_reg((b == 0) ? REG_Y_BOTTOM : REG_U_BOTTOM,
                          {32'($urandom), 16'($urandom), lo});
            end
            write_reg(REG_CLAMP_EN, {32'($urandom), 30'($urandom), 2'($urandom)});
            settings++;

            for (int i = 0; i < n_items; i++) begin
                // one phase also stops mid-stream until the pipe is empty
                if (ph == 4 && i == n_items / 2) begin
                    drain();
                end
                usel = $urandom_range(0, 9);
                if (usel < 6) begin
                    v = 16'($urandom);
                end else if (usel < 8) begin
                    v = 16'($urandom_range(0, 511) - 256);
                end else if (usel < 9) begin
                    v = corner_vals[$urandom_range(0, 4)];
                end else begin
                    v = last_v;   // held level, step-like input
                end
                last_v = v;
                queue_word(v);
            end
            drain();
        end

        repeat (10) @(posedge aclk);
        $display("Run covered %0d input words and %0d results over %0d settings (%0d writes).",
                 words_in, words_out, settings, reg_writes);
        $display("Saturated outputs: %0d, output clamps: %0d, input clamps: %0d, faults: %0d.",
                 n_sat, n_yclamp, n_uclamp, faults + y_due.size());
        if (faults == 0 && y_due.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // The slowest correct run ends well before this 5 ms watchdog.
    initial begin
        #5ms;
        $display("[%0t] timeout with %0d results outstanding", $realtime, y_due.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== arx_model_step.f =====
+incdir+rtl
rtl/arx_pkg.sv
rtl/arx_cfg.sv
rtl/arx_datapath.sv
rtl/arx_model_step.sv
tb/arx_model_step_tb.sv
